FILE: src/mpfc_pkg.sv
// Shared types, constants and coding functions of the Manchester parity frame codec.
package mpfc_pkg;

  localparam logic [7:0] PREAMBLE = 8'h33;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic        kind;
    logic [15:0] data;
  } mpfc_entry_t;

  function automatic logic [15:0] encode_word(input logic [6:0] value);
    logic [7:0]  word;
    logic [15:0] code;
    word = {^value, value};
    code = '0;
    for (int i = 0; i < 8; i++) begin
      code[15 - 2 * i] = ~word[i];
      code[14 - 2 * i] = word[i];
    end
    return code;
  endfunction

  // Returns {frame_ok, rx_value}.
  function automatic logic [7:0] decode_word(input logic [15:0] code);
    logic [7:0] word;
    logic       valid;
    word  = '0;
    valid = 1'b1;
    for (int i = 0; i < 8; i++) begin
      word[i] = ~code[15 - 2 * i] & code[14 - 2 * i];
      if (code[15 - 2 * i] == code[14 - 2 * i]) begin
        valid = 1'b0;
      end
    end
    if (!valid) begin
      return 8'h00;
    end
    return {(word[7] == ^word[6:0]), word[6:0]};
  endfunction

endpackage

FILE: src/mpfc_front.sv
// Front end: accepts requests, encodes transmit values and tracks the receive frame.
module mpfc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 func,
  input  logic [6:0]           tx_value,
  input  logic [7:0]           rx_byte,
  output logic                 push,
  output mpfc_pkg::mpfc_entry_t push_entry
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] low_r, low_nxt;
  logic       is_pre;

  assign is_pre = (rx_byte == mpfc_pkg::PREAMBLE);

  always_comb begin
    phase_nxt = phase_r;
    low_nxt   = low_r;
    push      = 1'b0;
    if (func == mpfc_pkg::KIND_TX) begin
      push_entry.kind = mpfc_pkg::KIND_TX;
      push_entry.data = mpfc_pkg::encode_word(tx_value);
    end else begin
      push_entry.kind = mpfc_pkg::KIND_RX;
      push_entry.data = {8'h00, mpfc_pkg::decode_word({rx_byte, low_r})};
    end
    if (accept) begin
      if (func == mpfc_pkg::KIND_TX) begin
        push = 1'b1;
      end else begin
        case (phase_r)
          PH_LOW: begin
            if (!is_pre) begin
              low_nxt   = rx_byte;
              phase_nxt = PH_HIGH;
            end
          end
          PH_HIGH: begin
            if (!is_pre) begin
              push      = 1'b1;
              phase_nxt = PH_WAIT;
            end
          end
          default: begin
            if (is_pre) begin
              phase_nxt = PH_LOW;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      low_r   <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

FILE: src/mpfc_queue.sv
// Small FIFO that carries classified work from the front end to the back end.
module mpfc_queue #(
  parameter int DEPTH = mpfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mpfc_pkg::mpfc_entry_t push_entry,
  input  logic                  pop,
  output mpfc_pkg::mpfc_entry_t head,
  output logic                  not_empty,
  output logic                  not_full
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  mpfc_pkg::mpfc_entry_t slots_r [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_ADDR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_ADDR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/mpfc_back.sv
// Back end: turns queued work into results and holds them in the output register.
module mpfc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mpfc_pkg::mpfc_entry_t head,
  input  logic                  head_valid,
  output logic                  pop,
  output logic                  mid_frame,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam logic [1:0] BEAT_IDLE = 2'd0;
  localparam logic [1:0] BEAT_LOW  = 2'd1;
  localparam logic [1:0] BEAT_HIGH = 2'd2;

  logic [1:0]  beat_r, beat_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] data_r, data_nxt;
  logic        kind_r, kind_nxt;
  logic        last_r, last_nxt;
  logic        slot_free;

  assign slot_free  = !valid_r || out_tready;
  assign pop        = slot_free && (beat_r == BEAT_IDLE) && head_valid;
  assign mid_frame  = (beat_r != BEAT_IDLE);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  always_comb begin
    beat_nxt  = beat_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    if (slot_free) begin
      valid_nxt = 1'b0;
      case (beat_r)
        BEAT_LOW: begin
          valid_nxt = 1'b1;
          kind_nxt  = mpfc_pkg::KIND_TX;
          data_nxt  = {8'h00, low_r};
          last_nxt  = 1'b0;
          beat_nxt  = BEAT_HIGH;
        end
        BEAT_HIGH: begin
          valid_nxt = 1'b1;
          kind_nxt  = mpfc_pkg::KIND_TX;
          data_nxt  = {8'h00, high_r};
          last_nxt  = 1'b1;
          beat_nxt  = BEAT_IDLE;
        end
        default: begin
          if (head_valid) begin
            valid_nxt = 1'b1;
            kind_nxt  = head.kind;
            if (head.kind == mpfc_pkg::KIND_TX) begin
              data_nxt = {8'h00, mpfc_pkg::PREAMBLE};
              last_nxt = 1'b0;
              low_nxt  = head.data[7:0];
              high_nxt = head.data[15:8];
              beat_nxt = BEAT_LOW;
            end else begin
              data_nxt = {head.data[7:0], 8'h00};
              last_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= BEAT_IDLE;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r <= high_nxt;
    low_r  <= low_nxt;
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

endmodule

FILE: src/manchester_parity_frame_codec.sv
// Top level of the Manchester parity frame codec.
//
//   Channel  Direction  Content
//   in_      slave      tdata {rx_byte, tx_value}, tuser func
//   out_     master     tdata {frame_ok, rx_value, line_byte}, tuser kind, tlast last
//
// One result leaves per cycle through the output register unless out_tready stalls
// it; a transmit request yields three results, a completed receive frame one.
// A request is accepted in the cycle it arrives while the work queue has room.
// Reset clears the receive frame state, the queue and the output valid flag.
// Either side may stall freely; the queue lets the front end accept while not full.
module manchester_parity_frame_codec #(
  parameter int QUEUE_DEPTH = mpfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] tx_value, [14:7] rx_byte, [15] zero
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] line_byte, [14:8] rx_value, [15] frame_ok
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);

  mpfc_pkg::mpfc_entry_t push_entry, head;
  logic push, pop, head_valid, not_full, mid_frame, accept;

  assign in_tready = not_full;
  assign accept    = in_tvalid && in_tready;

  mpfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .func       (in_tuser),
    .tx_value   (in_tdata[6:0]),
    .rx_byte    (in_tdata[14:7]),
    .push       (push),
    .push_entry (push_entry)
  );

  mpfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (head_valid),
    .not_full   (not_full)
  );

  mpfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .mid_frame  (mid_frame),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_rx_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mpfc_pkg::KIND_RX) |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("receive result is not a single last result");

  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    mid_frame |-> out_tvalid && (out_tuser == mpfc_pkg::KIND_TX) && !out_tlast)
    else $error("transmit frame in progress without a pending line byte");

  a_code_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mpfc_pkg::KIND_TX) && (out_tdata[7:0] != mpfc_pkg::PREAMBLE)
    |-> (((out_tdata[7:0] ^ {1'b0, out_tdata[7:1]}) & 8'h55) == 8'h55))
    else $error("transmitted code byte holds an invalid symbol pair");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("work queue written while full");

endmodule
